[hw/rtl/pidc_pkg.sv]
// Package: shared constants, register codes and configuration type for the PID regulator
`timescale 1ns / 1ps
`default_nettype none
package pidc_pkg;

  // Fixed field widths
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 23;
  localparam int THRESH_W = 17;
  localparam int TIME_W   = 32;
  localparam int INTEG_W  = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Output rounding: Q.20 sum to Q8.8, half toward plus infinity
  localparam int RND_SHIFT = 12;
  localparam int RND_HALF  = 2048;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIME_MS  = 3'd5;

  // Request kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // Reset value of the integral bound
  localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = 23'h7FFFFF;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] integ_gain_step;
    logic signed [GAIN_W-1:0] deriv_gain_step;
    logic [LIMIT_W-1:0]       integral_limit;
    logic [THRESH_W-1:0]      error_threshold;
    logic [TIME_W-1:0]        settle_time_ms;
  } cfg_t;

endpackage
`default_nettype wire

[hw/rtl/pidc_in_if.sv]
// Interface: input request channel (sample or settle query)
`timescale 1ns / 1ps
`default_nettype none
interface pidc_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [DATA_WIDTH-1:0] setpoint;
  logic signed [DATA_WIDTH-1:0] measurement;
  logic [31:0]                  now_ms;

  modport source (output valid, kind, setpoint, measurement, now_ms, input ready);
  modport sink (input valid, kind, setpoint, measurement, now_ms, output ready);
endinterface
`default_nettype wire

[hw/rtl/pidc_out_if.sv]
// Interface: result channel (drive and settle flag)
`timescale 1ns / 1ps
`default_nettype none
interface pidc_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive;
  logic                         settled;

  modport source (output valid, drive, settled, input ready);
  modport sink (input valid, drive, settled, output ready);
endinterface
`default_nettype wire

[hw/rtl/pidc_cfg_if.sv]
// Interface: configuration write channel
`timescale 1ns / 1ps
`default_nettype none
interface pidc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/pid_with_clamp_and_settle_detect_top.sv]
// Top level: PID regulator with integral clamp and settle detector
`timescale 1ns / 1ps
`default_nettype none
// Fixed-point PID regulator: a sample request (kind 0) returns the saturated
// Q8.8 drive kp*e + ki*I + kd*D with the integral clamped to the configured
// bound; a query request (kind 1) returns the settle flag. One request is
// taken every clock while the input is ready; each gives exactly one result
// via the input register, state update, product register and result register.
// The rate is set by the state update stage, where the integral add and clamp
// and the settle timer close their loop. A stalled result holds the pipeline
// only once all four stages are full. Configuration must be written with the
// pipeline empty; the block does not enforce it. The write port is always ready.
module pid_with_clamp_and_settle_detect_top
  import pidc_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pidc_cfg_if.sink    cfg,
  pidc_in_if.sink     item,
  pidc_out_if.source  result
);

  cfg_t regs;

  logic vld1;
  logic vld2;
  logic vld3;
  logic vld4;
  logic free1;
  logic free2;
  logic free3;
  logic free4;

  logic                         kind1;
  logic signed [DATA_WIDTH-1:0] setpoint1;
  logic signed [DATA_WIDTH-1:0] measurement1;
  logic [TIME_W-1:0]            now1;

  logic signed [DATA_WIDTH:0]  err2;
  logic signed [INTEG_W-1:0]   integ2;
  logic signed [DATA_WIDTH:0]  deriv2;
  logic                        query2;
  logic                        settled2;

  pidc_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Stage k takes a request when empty or when its occupant moves on
  always_comb begin
    free4 = !vld4 || result.ready;
    free3 = !vld3 || free4;
    free2 = !vld2 || free3;
    free1 = !vld1 || free2;
  end

  assign item.ready = free1;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
    end else begin
      if (free1) vld1 <= item.valid;
      if (free2) vld2 <= vld1;
      if (free3) vld3 <= vld2;
      if (free4) vld4 <= vld3;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (free1 && item.valid) begin
      kind1        <= item.kind;
      setpoint1    <= item.setpoint;
      measurement1 <= item.measurement;
      now1         <= item.now_ms;
    end
  end

  pidc_state #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_state (
    .clk         (clk),
    .rst         (rst),
    .adv         (free2 && vld1),
    .kind        (kind1),
    .setpoint    (setpoint1),
    .measurement (measurement1),
    .now_ms      (now1),
    .regs        (regs),
    .err_q       (err2),
    .integ_q     (integ2),
    .deriv_q     (deriv2),
    .query_q     (query2),
    .settled_q   (settled2)
  );

  pidc_mac #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mac (
    .clk       (clk),
    .ld_prod   (free3 && vld2),
    .ld_out    (free4 && vld3),
    .err       (err2),
    .integ     (integ2),
    .deriv     (deriv2),
    .query     (query2),
    .settled   (settled2),
    .regs      (regs),
    .drive_q   (result.drive),
    .settled_q (result.settled)
  );

  assign result.valid = vld4;

  // A settled report always comes from a query, which carries no drive
  a_settled_zero_drive: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.settled |-> result.drive == '0)
    else $error("settled result with non-zero drive");

  // Input stalls only when every stage is occupied
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> vld1 && vld2 && vld3 && vld4)
    else $error("input stalled with an empty stage");

  // An accepted request lands in the input stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> vld1)
    else $error("accepted request lost");

  // Nothing is presented right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

[hw/rtl/pidc_regs.sv]
// Module: configuration register file
`timescale 1ns / 1ps
`default_nettype none
module pidc_regs
  import pidc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  pidc_cfg_if.sink   cfg,
  output cfg_t       regs
);

  // Always take writes
  assign cfg.ready = 1'b1;

  // Write the addressed register, drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.prop_gain       <= '0;
      regs.integ_gain_step <= '0;
      regs.deriv_gain_step <= '0;
      regs.integral_limit  <= INTEGRAL_LIMIT_RST;
      regs.error_threshold <= '0;
      regs.settle_time_ms  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PROP_GAIN:       regs.prop_gain       <= cfg.data[GAIN_W-1:0];
        REG_INTEG_GAIN_STEP: regs.integ_gain_step <= cfg.data[GAIN_W-1:0];
        REG_DERIV_GAIN_STEP: regs.deriv_gain_step <= cfg.data[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT:  regs.integral_limit  <= cfg.data[LIMIT_W-1:0];
        REG_ERROR_THRESHOLD: regs.error_threshold <= cfg.data[THRESH_W-1:0];
        REG_SETTLE_TIME_MS:  regs.settle_time_ms  <= cfg.data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pidc_state.sv]
// Module: error, clamped integral, derivative and settle timer (state update stage)
`timescale 1ns / 1ps
`default_nettype none
module pidc_state
  import pidc_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         adv,
  input  wire logic                         kind,
  input  wire logic signed [DATA_WIDTH-1:0] setpoint,
  input  wire logic signed [DATA_WIDTH-1:0] measurement,
  input  wire logic [TIME_W-1:0]            now_ms,
  input  wire cfg_t                         regs,
  output logic signed [DATA_WIDTH:0]        err_q,
  output logic signed [INTEG_W-1:0]         integ_q,
  output logic signed [DATA_WIDTH:0]        deriv_q,
  output logic                              query_q,
  output logic                              settled_q
);

  localparam int EW = DATA_WIDTH + 1;
  localparam int AW = ((EW > INTEG_W) ? EW : INTEG_W) + 1;
  localparam int MW = (EW > THRESH_W) ? EW : THRESH_W;

  logic signed [INTEG_W-1:0]    integ_acc;
  logic signed [DATA_WIDTH-1:0] last_measurement;
  logic signed [EW-1:0]         last_error;
  logic                         settling;
  logic [TIME_W-1:0]            settle_start;

  logic signed [EW-1:0]      err;
  logic signed [EW-1:0]      deriv;
  logic signed [AW-1:0]      integ_sum;
  logic signed [AW-1:0]      lim_pos;
  logic signed [AW-1:0]      lim_neg;
  logic signed [INTEG_W-1:0] integ_next;
  logic [EW-1:0]             err_mag;
  logic                      err_small;
  logic [TIME_W-1:0]         elapsed;

  // Form error and derivative on the measurement
  always_comb begin
    err   = EW'(setpoint) - EW'(measurement);
    deriv = EW'(last_measurement) - EW'(measurement);
  end

  // Accumulate then clamp the integral
  always_comb begin
    integ_sum = AW'(integ_acc) + AW'(err);
    lim_pos   = $signed({{(AW-LIMIT_W){1'b0}}, regs.integral_limit});
    lim_neg   = -lim_pos;
    if (integ_sum > lim_pos) begin
      integ_next = INTEG_W'(lim_pos);
    end else if (integ_sum < lim_neg) begin
      integ_next = INTEG_W'(lim_neg);
    end else begin
      integ_next = INTEG_W'(integ_sum);
    end
  end

  // Compare error magnitude and elapsed time
  always_comb begin
    err_mag   = last_error[EW-1] ? EW'(-last_error) : EW'(last_error);
    err_small = MW'(err_mag) < MW'(regs.error_threshold);
    elapsed   = now_ms - settle_start;
  end

  // Update state on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc        <= '0;
      last_measurement <= '0;
      last_error       <= '0;
      settling         <= 1'b0;
      settle_start     <= '0;
    end else if (adv) begin
      if (kind == KIND_SAMPLE) begin
        integ_acc        <= integ_next;
        last_measurement <= measurement;
        last_error       <= err;
      end else if (!err_small) begin
        settling <= 1'b0;
      end else if (!settling) begin
        settling     <= 1'b1;
        settle_start <= now_ms;
      end
    end
  end

  // Hold operands for the multiply stage
  always_ff @(posedge clk) begin
    if (adv) begin
      err_q     <= err;
      integ_q   <= integ_next;
      deriv_q   <= deriv;
      query_q   <= kind;
      settled_q <= (kind == KIND_QUERY) && err_small && settling &&
                   (elapsed >= regs.settle_time_ms);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pidc_mac.sv]
// Module: gain products, rounding and saturation of the drive
`timescale 1ns / 1ps
`default_nettype none
module pidc_mac
  import pidc_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         ld_prod,
  input  wire logic                         ld_out,
  input  wire logic signed [DATA_WIDTH:0]   err,
  input  wire logic signed [INTEG_W-1:0]    integ,
  input  wire logic signed [DATA_WIDTH:0]   deriv,
  input  wire logic                         query,
  input  wire logic                         settled,
  input  wire cfg_t                         regs,
  output logic signed [DATA_WIDTH-1:0]      drive_q,
  output logic                              settled_q
);

  localparam int EW = DATA_WIDTH + 1;
  localparam int OW = (EW > INTEG_W) ? EW : INTEG_W;
  localparam int PW = GAIN_W + OW;
  localparam int SW = PW + 2;
  localparam int QW = SW - RND_SHIFT;

  logic signed [PW-1:0] p_prop;
  logic signed [PW-1:0] p_integ;
  logic signed [PW-1:0] p_deriv;
  logic                 query_p;
  logic                 settled_p;

  logic signed [SW-1:0]         acc;
  logic signed [SW-1:0]         acc_shift;
  logic signed [QW-1:0]         q;
  logic signed [QW-1:0]         q_max;
  logic signed [QW-1:0]         q_min;
  logic signed [DATA_WIDTH-1:0] sat;

  // Register the three products
  always_ff @(posedge clk) begin
    if (ld_prod) begin
      p_prop    <= PW'(regs.prop_gain) * PW'(err);
      p_integ   <= PW'(regs.integ_gain_step) * PW'(integ);
      p_deriv   <= PW'(regs.deriv_gain_step) * PW'(deriv);
      query_p   <= query;
      settled_p <= settled;
    end
  end

  // Sum, round to Q8.8 and saturate
  always_comb begin
    acc       = SW'(p_prop) + SW'(p_integ) + SW'(p_deriv) + SW'(RND_HALF);
    acc_shift = acc >>> RND_SHIFT;
    q         = acc_shift[QW-1:0];
    q_max     = $signed({{(QW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
    q_min     = ~q_max;
    if (q > q_max) begin
      sat = q_max[DATA_WIDTH-1:0];
    end else if (q < q_min) begin
      sat = q_min[DATA_WIDTH-1:0];
    end else begin
      sat = q[DATA_WIDTH-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ld_out) begin
      drive_q   <= (query_p == KIND_QUERY) ? '0 : sat;
      settled_q <= settled_p;
    end
  end

endmodule
`default_nettype wire

[tb/sv/pidc_result_checker.sv]
// Checker: predicts the PID regulator results from observed requests and compares them
`timescale 1ns / 1ps
module pidc_result_checker
  import pidc_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pidc_cfg_if         cfg,
  pidc_in_if          item,
  pidc_out_if         result,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam longint DRIVE_MAX = (longint'(1) << (DATA_WIDTH - 1)) - 1;
  localparam longint DRIVE_MIN = -DRIVE_MAX - 1;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] drive;
    logic                         settled;
  } pid_result_t;

  // Register copy and regulator state
  cfg_t                         regs;
  longint                       integ;
  logic signed [DATA_WIDTH-1:0] prev_meas;
  longint                       prev_err;
  bit                           settle_run;
  logic [TIME_W-1:0]            settle_t0;

  pid_result_t pending_outputs[$];

  // Advance the regulator by one request and return the result it gives
  function automatic pid_result_t step_regulator(
    input logic                         kind,
    input logic signed [DATA_WIDTH-1:0] sp,
    input logic signed [DATA_WIDTH-1:0] meas,
    input logic [TIME_W-1:0]            now
  );
    pid_result_t       r;
    longint            err;
    longint            slope;
    longint            lim;
    longint            sum;
    longint            q;
    longint            mag;
    logic [TIME_W-1:0] span;
    r.drive   = '0;
    r.settled = 1'b0;
    if (kind == KIND_SAMPLE) begin
      err      = longint'(sp) - longint'(meas);
      slope    = longint'(prev_meas) - longint'(meas);
      lim      = longint'(regs.integral_limit);
      prev_err = err;
      // Add the error first, then clamp the integral
      integ = integ + err;
      if (integ > lim) begin
        integ = lim;
      end else if (integ < -lim) begin
        integ = -lim;
      end
      sum = longint'($signed(regs.prop_gain)) * err
          + longint'($signed(regs.integ_gain_step)) * integ
          + longint'($signed(regs.deriv_gain_step)) * slope;
      prev_meas = meas;
      // Round half up to Q8.8, then saturate
      q = (sum + RND_HALF) >>> RND_SHIFT;
      if (q > DRIVE_MAX) q = DRIVE_MAX;
      if (q < DRIVE_MIN) q = DRIVE_MIN;
      r.drive = q[DATA_WIDTH-1:0];
    end else begin
      mag = (prev_err < 0) ? -prev_err : prev_err;
      if (mag < longint'(regs.error_threshold)) begin
        if (!settle_run) begin
          settle_t0  = now;
          settle_run = 1'b1;
        end else begin
          span      = now - settle_t0;
          r.settled = (span >= regs.settle_time_ms);
        end
      end else begin
        settle_run = 1'b0;
      end
    end
    return r;
  endfunction

  // Track writes, check results, then queue the prediction for a new request
  always @(posedge clk) begin
    pid_result_t want;
    if (rst) begin
      regs.prop_gain       = '0;
      regs.integ_gain_step = '0;
      regs.deriv_gain_step = '0;
      regs.integral_limit  = INTEGRAL_LIMIT_RST;
      regs.error_threshold = '0;
      regs.settle_time_ms  = '0;
      integ      = 0;
      prev_meas  = '0;
      prev_err   = 0;
      settle_run = 1'b0;
      settle_t0  = '0;
      pending_outputs.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_PROP_GAIN:       regs.prop_gain       = cfg.data[GAIN_W-1:0];
          REG_INTEG_GAIN_STEP: regs.integ_gain_step = cfg.data[GAIN_W-1:0];
          REG_DERIV_GAIN_STEP: regs.deriv_gain_step = cfg.data[GAIN_W-1:0];
          REG_INTEGRAL_LIMIT:  regs.integral_limit  = cfg.data[LIMIT_W-1:0];
          REG_ERROR_THRESHOLD: regs.error_threshold = cfg.data[THRESH_W-1:0];
          REG_SETTLE_TIME_MS:  regs.settle_time_ms  = cfg.data[TIME_W-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (pending_outputs.size() == 0) begin
          $display("%0t: result with nothing outstanding, drive %0d settled %0b",
                   $time, result.drive, result.settled);
          fail_count++;
        end else begin
          want = pending_outputs.pop_front();
          if (result.drive !== want.drive) begin
            $display("%0t: drive mismatch, expected %0d, got %0d",
                     $time, want.drive, result.drive);
            fail_count++;
          end
          if (result.settled !== want.settled) begin
            $display("%0t: settled mismatch, expected %0b, got %0b",
                     $time, want.settled, result.settled);
            fail_count++;
          end
        end
      end
      if (item.valid && item.ready) begin
        pending_outputs.push_back(step_regulator(item.kind, item.setpoint,
                                                 item.measurement, item.now_ms));
      end
    end
    pending = pending_outputs.size();
  end

endmodule

[tb/sv/tb_pid_with_clamp_and_settle_detect_top.sv]
// Testbench top: clock, reset, request and configuration stimulus, result stalls, verdict
`timescale 1ns / 1ps
module tb_pid_with_clamp_and_settle_detect_top;
  import pidc_pkg::*;

  localparam int DATA_WIDTH = 16;
  localparam int PIPE_DEPTH = 4;
  localparam int HOLD_CYCLES = 80;

  // Indexes past the last register
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;

  logic clk;
  logic rst;

  pidc_cfg_if                            cfg_ch ();
  pidc_in_if  #(.DATA_WIDTH(DATA_WIDTH)) req_ch ();
  pidc_out_if #(.DATA_WIDTH(DATA_WIDTH)) res_ch ();

  int unsigned fail_count;
  int unsigned pending;

  // Sender pacing and receiver stall controls
  int          gap_max;
  int          burst_left;
  int          rx_mode;
  int unsigned hold_asks;
  int unsigned hold_seen;
  int          hold_left;
  int unsigned rx_tick;

  // Stimulus view of the current settings and of wall time
  logic [THRESH_W-1:0] cur_thresh;
  logic [TIME_W-1:0]   cur_settle;
  logic [TIME_W-1:0]   ms_now;

  pid_with_clamp_and_settle_detect_top #(.DATA_WIDTH(DATA_WIDTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (req_ch),
    .result (res_ch)
  );

  pidc_result_checker #(.DATA_WIDTH(DATA_WIDTH)) pid_check (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .item       (req_ch),
    .result     (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop for a hung run
  initial begin
    #2_000_000;
    $display("tb_pid_with_clamp_and_settle_detect_top: FAIL");
    $finish;
  end

  // Receiver: stall on the current pattern, or hold off for a long stretch on request
  initial begin
    res_ch.ready = 1'b0;
    hold_seen    = 0;
    hold_left    = 0;
    rx_tick      = 0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_ch.ready = 1'b0;
        hold_left--;
      end else begin
        case (rx_mode)
          0:       res_ch.ready = 1'b1;
          1:       res_ch.ready = ($urandom_range(0, 3) != 0);
          2:       res_ch.ready = ((rx_tick % 7) < 3);
          default: res_ch.ready = ($urandom_range(0, 1) == 1);
        endcase
      end
    end
  end

  // Write one register; call at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    if (idx == REG_ERROR_THRESHOLD) cur_thresh = val[THRESH_W-1:0];
    if (idx == REG_SETTLE_TIME_MS) cur_settle = val;
  endtask

  // Offer one request, with a random gap at the start of each burst
  task automatic send_req(input logic kind, input logic signed [DATA_WIDTH-1:0] sp,
                          input logic signed [DATA_WIDTH-1:0] meas,
                          input logic [TIME_W-1:0] now);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max > 0) begin
        req_ch.valid = 1'b0;
        repeat ($urandom_range(0, gap_max)) @(negedge clk);
      end
    end
    burst_left--;
    req_ch.kind        = kind;
    req_ch.setpoint    = sp;
    req_ch.measurement = meas;
    req_ch.now_ms      = now;
    req_ch.valid       = 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    logic [GAIN_W-1:0] g;
    case ($urandom_range(0, 3))
      0:       g = GAIN_W'($urandom_range(0, 16'h1000));
      1:       g = -GAIN_W'($urandom_range(0, 16'h1000));
      2:       g = GAIN_W'($urandom());
      default: g = ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
    endcase
    return g;
  endfunction

  // Write every register with a fresh setting; upper data bits carry noise
  task automatic random_config();
    logic [31:0] w;
    w = $urandom();
    write_reg(REG_PROP_GAIN, {w[31:GAIN_W], pick_gain()});
    w = $urandom();
    write_reg(REG_INTEG_GAIN_STEP, {w[31:GAIN_W], pick_gain()});
    w = $urandom();
    write_reg(REG_DERIV_GAIN_STEP, {w[31:GAIN_W], pick_gain()});
    w = $urandom();
    case ($urandom_range(0, 4))
      0:       w[LIMIT_W-1:0] = '0;
      1, 2:    w[LIMIT_W-1:0] = LIMIT_W'($urandom_range(1, 20000));
      3:       w[LIMIT_W-1:0] = '1;
      default: w[LIMIT_W-1:0] = LIMIT_W'($urandom_range(0, 23'h7FFFFF));
    endcase
    write_reg(REG_INTEGRAL_LIMIT, w);
    w = $urandom();
    case ($urandom_range(0, 5))
      0:       w[THRESH_W-1:0] = '0;
      4:       w[THRESH_W-1:0] = '1;
      5:       w[THRESH_W-1:0] = THRESH_W'($urandom_range(0, 17'h1FFFF));
      default: w[THRESH_W-1:0] = THRESH_W'($urandom_range(1, 2000));
    endcase
    write_reg(REG_ERROR_THRESHOLD, w);
    case ($urandom_range(0, 5))
      0:       w = '0;
      4:       w = '1;
      5:       w = $urandom();
      default: w = $urandom_range(1, 60);
    endcase
    write_reg(REG_SETTLE_TIME_MS, w);
  endtask

  // One random request: mostly samples, most of them near the setpoint, and some queries
  task automatic random_req();
    logic signed [DATA_WIDTH-1:0] sp;
    logic signed [DATA_WIDTH-1:0] meas;
    logic signed [DATA_WIDTH-1:0] d;
    int                           lim;
    int                           step;
    if ($urandom_range(0, 9) < 3) begin
      if ($urandom_range(0, 19) == 0) begin
        ms_now = $urandom();
      end else begin
        step   = (cur_settle > 50) ? 50 : int'(cur_settle) + 5;
        ms_now = ms_now + $urandom_range(0, step);
      end
      send_req(KIND_QUERY, DATA_WIDTH'($urandom()), DATA_WIDTH'($urandom()), ms_now);
    end else begin
      sp = DATA_WIDTH'($urandom());
      if ($urandom_range(0, 9) < 7) begin
        lim  = (cur_thresh > 2000) ? 4000 : int'(cur_thresh) * 2 + 4;
        d    = DATA_WIDTH'($urandom_range(0, lim));
        meas = ($urandom_range(0, 1) == 1) ? sp + d : sp - d;
      end else begin
        meas = DATA_WIDTH'($urandom());
      end
      send_req(KIND_SAMPLE, sp, meas, $urandom());
    end
  endtask

  // Main sequence
  initial begin
    rst                = 1'b1;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    req_ch.valid       = 1'b0;
    req_ch.kind        = KIND_SAMPLE;
    req_ch.setpoint    = '0;
    req_ch.measurement = '0;
    req_ch.now_ms      = '0;
    gap_max            = 0;
    burst_left         = 0;
    rx_mode            = 0;
    hold_asks          = 0;
    cur_thresh         = '0;
    cur_settle         = '0;
    ms_now             = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Query before any sample, under reset settings
    send_req(KIND_QUERY, 16'sd0, 16'sd0, 32'd0);
    wait_drained();

    // Moderate gains, tight integral bound, unit threshold
    write_reg(REG_PROP_GAIN, 32'h0000_1000);
    write_reg(REG_INTEG_GAIN_STEP, 32'h0000_0100);
    write_reg(REG_DERIV_GAIN_STEP, 32'h0000_0800);
    write_reg(REG_INTEGRAL_LIMIT, 32'd1000);
    write_reg(REG_ERROR_THRESHOLD, 32'd256);
    write_reg(REG_SETTLE_TIME_MS, 32'd10);
    // Indexes past the last register are dropped
    write_reg(SPARE_IDX_LO, $urandom());
    write_reg(SPARE_IDX_HI, $urandom());
    // Extreme errors drive the integral against both bounds
    send_req(KIND_SAMPLE, 16'sh7FFF, -16'sh8000, 32'd0);
    send_req(KIND_SAMPLE, -16'sh8000, 16'sh7FFF, 32'hFFFF_FFFF);
    send_req(KIND_SAMPLE, 16'sd0, 16'sd0, 32'd0);
    send_req(KIND_SAMPLE, -16'sh8000, -16'sh8000, 32'd0);
    send_req(KIND_SAMPLE, 16'sd100, 16'sd50, 32'd0);
    // Settle timer: start, not yet, exactly reached
    send_req(KIND_QUERY, 16'sd0, 16'sd0, 32'd100);
    send_req(KIND_QUERY, 16'sd0, 16'sd0, 32'd105);
    send_req(KIND_QUERY, 16'sd0, 16'sd0, 32'd110);
    // Error equal to the threshold is not small: timer drops
    send_req(KIND_SAMPLE, 16'sd0, 16'sd256, 32'd0);
    send_req(KIND_QUERY, 16'sd0, 16'sd0, 32'd120);
    // Settle across the wrap of the millisecond counter
    send_req(KIND_SAMPLE, 16'sd10, 16'sd0, 32'd0);
    send_req(KIND_QUERY, 16'sd0, 16'sd0, 32'hFFFF_FFF8);
    send_req(KIND_QUERY, 16'sd0, 16'sd0, 32'd5);
    wait_drained();

    // Half-way rounding both sides, zero integral bound, widest threshold, zero time
    write_reg(REG_PROP_GAIN, 32'h0000_0800);
    write_reg(REG_INTEG_GAIN_STEP, 32'h0000_0000);
    write_reg(REG_DERIV_GAIN_STEP, 32'h0000_0000);
    write_reg(REG_INTEGRAL_LIMIT, 32'd0);
    write_reg(REG_ERROR_THRESHOLD, 32'h0001_FFFF);
    write_reg(REG_SETTLE_TIME_MS, 32'd0);
    send_req(KIND_SAMPLE, 16'sd1, 16'sd0, 32'd0);
    send_req(KIND_SAMPLE, 16'sd0, 16'sd1, 32'd0);
    send_req(KIND_QUERY, 16'sd0, 16'sd0, 32'd7);
    send_req(KIND_QUERY, 16'sd0, 16'sd0, 32'd7);
    wait_drained();

    // Extreme gains: saturate both ways; zero threshold never settles
    write_reg(REG_PROP_GAIN, 32'h0000_7FFF);
    write_reg(REG_INTEG_GAIN_STEP, 32'h0000_7FFF);
    write_reg(REG_DERIV_GAIN_STEP, 32'h0000_8000);
    write_reg(REG_INTEGRAL_LIMIT, 32'h007F_FFFF);
    write_reg(REG_ERROR_THRESHOLD, 32'd0);
    write_reg(REG_SETTLE_TIME_MS, 32'hFFFF_FFFF);
    send_req(KIND_SAMPLE, 16'sh7FFF, -16'sh8000, 32'd0);
    send_req(KIND_SAMPLE, -16'sh8000, 16'sh7FFF, 32'd0);
    send_req(KIND_SAMPLE, -16'sh8000, 16'sh7FFF, 32'd0);
    send_req(KIND_QUERY, 16'sd0, 16'sd0, 32'd9);
    send_req(KIND_QUERY, 16'sd0, 16'sd0, 32'd9);

    // Random phases, each with its own setting and pacing
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      random_config();
      rx_mode = ph % 4;
      gap_max = (ph % 3 == 0) ? 0 : $urandom_range(1, 6);
      if (ph == 3) begin
        // Hold the receiver off while requests keep coming, so the input stalls
        gap_max = 0;
        hold_asks++;
        repeat (30) random_req();
      end
      for (int n = 0; n < 60; n++) begin
        if (ph == 5 && n == 30) wait_drained();
        random_req();
      end
    end

    wait_drained();
    repeat (PIPE_DEPTH * 3) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_pid_with_clamp_and_settle_detect_top: PASS");
    end else begin
      $display("tb_pid_with_clamp_and_settle_detect_top: FAIL");
    end
    $finish;
  end

endmodule
